>>> hdl/psg_pkg.sv
// shared types, constants and mod-251 arithmetic for the share generator
// used by psg_cell and polynomial_share_generator_gf251; no dependencies
`default_nettype none

package psg_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned MAX_SHARES_DEF    = 16;
  localparam int unsigned MAX_THRESHOLD_DEF = 16;

  // field arithmetic
  localparam int unsigned GF_PRIME = 251;
  localparam int unsigned GF_FOLD  = 5;    // 256 mod 251

  // configuration port
  localparam int unsigned CFG_WIDTH     = 5;
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SHARE_COUNT = 2'd1;
  localparam logic [CFG_WIDTH-1:0]     THRESHOLD_RESET   = 5'd2;
  localparam logic [CFG_WIDTH-1:0]     SHARE_COUNT_RESET = 5'd2;
  localparam int unsigned MIN_THRESHOLD = 2;
  localparam int unsigned MIN_SHARES    = 2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_BURST
  } psg_state_t;

  // control handed to every cell of the row
  typedef struct packed {
    logic mul;        // latch products for a new coefficient
    logic upd;        // fold products into sum and power
    logic grp_end;    // group done: power returns to one
    logic shift;      // move sums one cell toward the output
    logic clear;      // burst done: sums return to zero
  } psg_ctrl_t;

  // reduce any 16-bit value mod 251 by folding the high byte twice
  function automatic logic [7:0] gf_reduce(input logic [15:0] v);
    logic [10:0] t1;
    logic [8:0]  t2;
    t1 = 11'(v[15:8]) * 11'(GF_FOLD) + 11'(v[7:0]);
    t2 = 9'(t1[10:8]) * 9'(GF_FOLD) + 9'(t1[7:0]);
    if (t2 >= 9'(GF_PRIME)) begin
      t2 = t2 - 9'(GF_PRIME);
    end
    return t2[7:0];
  endfunction

  // sum of two residues mod 251
  function automatic logic [7:0] gf_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    if (s >= 9'(GF_PRIME)) begin
      s = s - 9'(GF_PRIME);
    end
    return s[7:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/psg_cell.sv
// one evaluation point: running sum and power of x, mod 251
// depends on psg_pkg for control struct and field arithmetic
`default_nettype none

module psg_cell
  import psg_pkg::*;
#(
  parameter int unsigned X = 1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire psg_ctrl_t ctrl,
  input  wire logic [7:0] coef,
  input  wire logic [7:0] sum_in,
  output logic      [7:0] sum_out
);

  logic [7:0]  sum;
  logic [7:0]  power;
  logic [15:0] coef_prod;
  logic [15:0] power_prod;

  // products for the coefficient being taken in
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      coef_prod  <= 16'(coef) * 16'(power);
      power_prod <= 16'(power) * 16'(X);
    end
  end

  // accumulate, shift toward the output, or clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= 8'd0;
      power <= 8'd1;
    end else if (ctrl.clear) begin
      sum <= 8'd0;
    end else if (ctrl.shift) begin
      sum <= sum_in;
    end else if (ctrl.upd) begin
      sum   <= gf_add(sum, gf_reduce(coef_prod));
      power <= ctrl.grp_end ? 8'd1 : gf_reduce(power_prod);
    end
  end

  assign sum_out = sum;

endmodule

`default_nettype wire

>>> hdl/polynomial_share_generator_gf251.sv
// top level: sequencer, configuration registers and the row of point cells
// depends on psg_pkg and psg_cell
//
//   channel  signals                                  direction
//   in       in_valid, in_stall, pixel                pixel bytes in
//   out      out_valid, out_stall, shadow_pixel,      one transaction per share
//            share_index, last_share
//   cfg      cfg_write, cfg_index, cfg_data           register writes
//
// for each pixel the accept cycle latches the products in every cell, the
// next cycle folds them into sum and power (one multiplier pair per cell)
// while in_stall is high. the pixel that closes a group adds a burst of
// output transactions, one per share, with sums shifting one cell per
// accepted transaction. out_stall holds the burst and in_stall is high
// until it drains. reset is synchronous and needs no sweep.
`default_nettype none

module polynomial_share_generator_gf251
  import psg_pkg::*;
#(
  parameter int unsigned MAX_SHARES    = MAX_SHARES_DEF,
  parameter int unsigned MAX_THRESHOLD = MAX_THRESHOLD_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               pixel,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [7:0]                    shadow_pixel,
  output logic [3:0]                    share_index,
  output logic                          last_share,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

  localparam int unsigned PW = $clog2(MAX_THRESHOLD + 1);
  localparam int unsigned NW = $clog2(MAX_SHARES + 1);
  localparam int unsigned SW = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;

  psg_state_t state, state_next;
  logic [CFG_WIDTH-1:0] threshold;
  logic [CFG_WIDTH-1:0] share_count;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        pos_inc;
  logic [SW-1:0]        cnt;
  logic [PW-1:0]        eff_r;
  logic [NW-1:0]        eff_n;
  logic [7:0]           th_wide;
  logic [7:0]           sc_wide;
  logic [7:0]           idx_wide;
  logic [7:0]           coef;
  logic                 in_accept;
  logic                 out_accept;
  logic                 grp_done;
  psg_ctrl_t            ctrl;
  logic [7:0]           sum_link [MAX_SHARES+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RESET;
      share_count <= SHARE_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD:   threshold   <= cfg_data;
        REG_SHARE_COUNT: share_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective threshold and share count, clamped to the supported range
  always_comb begin
    th_wide = 8'(threshold);
    sc_wide = 8'(share_count);
    if (th_wide < 8'(MIN_THRESHOLD)) begin
      th_wide = 8'(MIN_THRESHOLD);
    end else if (th_wide > 8'(MAX_THRESHOLD)) begin
      th_wide = 8'(MAX_THRESHOLD);
    end
    if (sc_wide < 8'(MIN_SHARES)) begin
      sc_wide = 8'(MIN_SHARES);
    end else if (sc_wide > 8'(MAX_SHARES)) begin
      sc_wide = 8'(MAX_SHARES);
    end
  end

  assign eff_r = th_wide[PW-1:0];
  assign eff_n = sc_wide[NW-1:0];

  // handshakes and group bookkeeping
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign pos_inc    = pos + PW'(1);
  assign grp_done   = (pos_inc >= eff_r);
  assign last_share = ((NW'(cnt) + NW'(1)) == eff_n);

  // pixel bytes at or above the prime wrap into the field
  assign coef = (pixel >= 8'(GF_PRIME)) ? (pixel - 8'(GF_PRIME)) : pixel;

  // state register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE) begin
        pos <= grp_done ? '0 : pos_inc;
      end
      if (out_accept) begin
        cnt <= last_share ? '0 : cnt + SW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = grp_done ? ST_BURST : ST_IDLE;
      end
      ST_BURST: begin
        if (out_accept && last_share) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs and cell control
  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    ctrl         = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctrl.mul = in_valid;
      end
      ST_UPDATE: begin
        ctrl.upd     = 1'b1;
        ctrl.grp_end = grp_done;
      end
      ST_BURST: begin
        out_valid   = 1'b1;
        ctrl.shift  = out_accept;
        ctrl.clear  = out_accept && last_share;
      end
      default: ;
    endcase
  end

  // row of evaluation points, sums drain toward cell zero
  assign sum_link[MAX_SHARES] = 8'd0;

  for (genvar k = 0; k < MAX_SHARES; k++) begin : g_cell
    psg_cell #(
      .X (k + 1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .coef    (coef),
      .sum_in  (sum_link[k+1]),
      .sum_out (sum_link[k])
    );
  end

  // result fields
  assign shadow_pixel = sum_link[0];
  assign idx_wide     = 8'(cnt);
  assign share_index  = idx_wide[3:0];

endmodule

`default_nettype wire
